// ===== sv/wkf_pkg.sv =====
// Shared types, constants and helpers for the window kernel image filter.
// Used by wkf_kernel and window_kernel_image_filter_top; depends on nothing.
`default_nettype none
package wkf_pkg;

   localparam int MAX_WIDTH  = 1024;
   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int ROWS_HELD  = 4;
   localparam int PIX_W      = 16;
   localparam int LINE_W     = ROWS_HELD * PIX_W;
   localparam int ADDR_W     = 4;

   localparam logic [10:0] WIDTH_MAX  = 11'(MAX_WIDTH);
   localparam logic [10:0] WIDTH_MIN  = 11'd5;
   localparam logic [15:0] HEIGHT_MIN = 16'd5;

   typedef logic [PIX_W-1:0]           pix_type;
   typedef logic [COL_W-1:0]           col_type;
   typedef logic [4:0][4:0][PIX_W-1:0] win_type;   // [column][row]

   typedef struct packed {
      logic emit;
      logic last;
      logic pass;
   } ctl_type;

   localparam logic [3:0] MODE_MEAN      = 4'd0;
   localparam logic [3:0] MODE_MEDIAN    = 4'd1;
   localparam logic [3:0] MODE_GAUSS     = 4'd2;
   localparam logic [3:0] MODE_ROBERTS   = 4'd3;
   localparam logic [3:0] MODE_PREWITT   = 4'd4;
   localparam logic [3:0] MODE_SOBEL     = 4'd5;
   localparam logic [3:0] MODE_LAPLACIAN = 4'd6;
   localparam logic [3:0] MODE_LOG       = 4'd7;
   localparam logic [3:0] MODE_IMPROVED  = 4'd8;

   localparam logic [1:0] REG_MODE   = 2'd0;
   localparam logic [1:0] REG_WIDTH  = 2'd1;
   localparam logic [1:0] REG_HEIGHT = 2'd2;

   // floor(n/9) == (n*MEAN_RECIP) >> MEAN_SHIFT for every 20-bit n in use
   localparam logic [19:0] MEAN_RECIP = 20'd932068;
   localparam int          MEAN_SHIFT = 23;
   localparam logic [10:0] IMP_GAIN   = 11'd1843;

   function automatic logic signed [23:0] ext24(input pix_type v);
      return $signed({8'd0, v});
   endfunction

endpackage
`default_nettype wire

// ===== sv/wkf_kernel.sv =====
// Arithmetic pipeline of the filter: three stages from a 5x5 window to a result.
// Depends on wkf_pkg; the last stage is the result register.
`default_nettype none
module wkf_kernel (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_valid,
   input  wkf_pkg::ctl_type in_ctl,
   input  wkf_pkg::win_type win,
   input  logic [3:0]       mode,
   output logic             out_valid,
   output logic signed [15:0] out_pixel,
   output logic             out_last
);
   import wkf_pkg::*;

   function automatic pix_type min16(input pix_type a, input pix_type b);
      return (a < b) ? a : b;
   endfunction

   function automatic pix_type max16(input pix_type a, input pix_type b);
      return (a > b) ? a : b;
   endfunction

   function automatic pix_type med3(input pix_type a, input pix_type b, input pix_type c);
      return max16(min16(a, b), min16(max16(a, b), c));
   endfunction

   // stage 1
   pix_type t_mm, t_m0, t_mp, t_0m, t_00, t_0p, t_pm, t_p0, t_pp;
   pix_type t_n2, t_s2, t_w2, t_e2;
   logic [19:0] sum9, gsum, gsum_r;
   logic signed [23:0] rb_a, rb_b, px, py, sx, sy, lap, lg;
   logic [17:0] rb_a_abs, rb_b_abs;

   logic        v1_ff;
   ctl_type     ctl1_ff;
   pix_type     p1_ff, gauss1_ff;
   logic [19:0] mean_n1_ff;
   logic [16:0] rob1_ff;
   logic signed [18:0] prx1_ff, pry1_ff, sbx1_ff, sby1_ff;
   logic signed [21:0] lap1_ff;
   logic signed [20:0] log1_ff;
   pix_type     r_mn1_ff [3], r_md1_ff [3], r_mx1_ff [3];

   always_comb begin
      t_mm = win[1][1]; t_m0 = win[2][1]; t_mp = win[3][1];
      t_0m = win[1][2]; t_00 = win[2][2]; t_0p = win[3][2];
      t_pm = win[1][3]; t_p0 = win[2][3]; t_pp = win[3][3];
      t_n2 = win[2][0]; t_s2 = win[2][4]; t_w2 = win[0][2]; t_e2 = win[4][2];
      sum9 = 20'(t_mm) + 20'(t_m0) + 20'(t_mp) + 20'(t_0m) + 20'(t_00)
           + 20'(t_0p) + 20'(t_pm) + 20'(t_p0) + 20'(t_pp);
      gsum = 20'(t_mm) + 20'(t_mp) + 20'(t_pm) + 20'(t_pp)
           + ((20'(t_m0) + 20'(t_p0) + 20'(t_0m) + 20'(t_0p)) << 1)
           + (20'(t_00) << 2);
      gsum_r = gsum + 20'd8;
      rb_a = ext24(t_pp) - ext24(t_00);
      rb_b = ext24(t_0p) - ext24(t_p0);
      rb_a_abs = rb_a[23] ? 18'(-rb_a) : 18'(rb_a);
      rb_b_abs = rb_b[23] ? 18'(-rb_b) : 18'(rb_b);
      px = ext24(t_mm) + ext24(t_m0) + ext24(t_mp)
         - ext24(t_pm) - ext24(t_p0) - ext24(t_pp);
      py = ext24(t_mm) + ext24(t_0m) + ext24(t_pm)
         - ext24(t_mp) - ext24(t_0p) - ext24(t_pp);
      sx = ext24(t_mm) + (ext24(t_m0) <<< 1) + ext24(t_mp)
         - ext24(t_pm) - (ext24(t_p0) <<< 1) - ext24(t_pp);
      sy = ext24(t_mm) + (ext24(t_0m) <<< 1) + ext24(t_pm)
         - ext24(t_mp) - (ext24(t_0p) <<< 1) - ext24(t_pp);
      lap = ext24(t_mm) + ext24(t_mp) + ext24(t_pm) + ext24(t_pp)
          + ((ext24(t_m0) + ext24(t_p0) + ext24(t_0m) + ext24(t_0p)) <<< 2)
          - ext24(t_00) * 24'sd20;
      lg = (ext24(t_00) <<< 4) - ext24(t_n2) - ext24(t_s2) - ext24(t_w2) - ext24(t_e2)
         - ext24(t_mm) - ext24(t_mp) - ext24(t_pm) - ext24(t_pp)
         - ((ext24(t_m0) + ext24(t_p0) + ext24(t_0m) + ext24(t_0p)) <<< 1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
      end
      if (en) begin
         ctl1_ff    <= in_ctl;
         p1_ff      <= t_00;
         mean_n1_ff <= sum9 + 20'd4;
         gauss1_ff  <= gsum_r[19:4];
         rob1_ff    <= 17'(rb_a_abs) + 17'(rb_b_abs);
         prx1_ff    <= 19'(px);
         pry1_ff    <= 19'(py);
         sbx1_ff    <= 19'(sx);
         sby1_ff    <= 19'(sy);
         lap1_ff    <= 22'(lap);
         log1_ff    <= 21'(lg);
         r_mn1_ff[0] <= min16(min16(t_mm, t_m0), t_mp);
         r_md1_ff[0] <= med3(t_mm, t_m0, t_mp);
         r_mx1_ff[0] <= max16(max16(t_mm, t_m0), t_mp);
         r_mn1_ff[1] <= min16(min16(t_0m, t_00), t_0p);
         r_md1_ff[1] <= med3(t_0m, t_00, t_0p);
         r_mx1_ff[1] <= max16(max16(t_0m, t_00), t_0p);
         r_mn1_ff[2] <= min16(min16(t_pm, t_p0), t_pp);
         r_md1_ff[2] <= med3(t_pm, t_p0, t_pp);
         r_mx1_ff[2] <= max16(max16(t_pm, t_p0), t_pp);
      end
   end

   // stage 2
   logic        v2_ff;
   ctl_type     ctl2_ff;
   pix_type     p2_ff, gauss2_ff, lo2_ff, mid2_ff, hi2_ff;
   logic [39:0] mean_prod2_ff;
   logic [16:0] rob2_ff;
   logic [18:0] prew2_ff, sob2_ff;
   logic [20:0] lap_abs2_ff;
   logic [19:0] log_abs2_ff;
   logic signed [21:0] lap2_ff;
   logic [26:0] imp_prod2_ff;
   logic [17:0] prx_a, pry_a, sbx_a, sby_a;

   always_comb begin
      prx_a = prx1_ff[18] ? 18'(-prx1_ff) : 18'(prx1_ff);
      pry_a = pry1_ff[18] ? 18'(-pry1_ff) : 18'(pry1_ff);
      sbx_a = sbx1_ff[18] ? 18'(-sbx1_ff) : 18'(sbx1_ff);
      sby_a = sby1_ff[18] ? 18'(-sby1_ff) : 18'(sby1_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en) begin
         v2_ff <= v1_ff;
      end
      if (en) begin
         ctl2_ff       <= ctl1_ff;
         p2_ff         <= p1_ff;
         gauss2_ff     <= gauss1_ff;
         rob2_ff       <= rob1_ff;
         mean_prod2_ff <= 40'(mean_n1_ff) * 40'(MEAN_RECIP);
         prew2_ff      <= 19'(prx_a) + 19'(pry_a);
         sob2_ff       <= 19'(sbx_a) + 19'(sby_a);
         lap_abs2_ff   <= lap1_ff[21] ? 21'(-lap1_ff) : 21'(lap1_ff);
         log_abs2_ff   <= log1_ff[20] ? 20'(-log1_ff) : 20'(log1_ff);
         lap2_ff       <= lap1_ff;
         imp_prod2_ff  <= 27'(p1_ff) * 27'(IMP_GAIN);
         lo2_ff  <= max16(max16(r_mn1_ff[0], r_mn1_ff[1]), r_mn1_ff[2]);
         mid2_ff <= med3(r_md1_ff[0], r_md1_ff[1], r_md1_ff[2]);
         hi2_ff  <= min16(min16(r_mx1_ff[0], r_mx1_ff[1]), r_mx1_ff[2]);
      end
   end

   // stage 3: select, round, saturate
   logic signed [32:0] imp_num;
   logic signed [23:0] sel;
   logic signed [15:0] sat;
   logic [16:0]        mean_q;

   always_comb begin
      imp_num = $signed({6'd0, imp_prod2_ff})
              - ($signed({{11{lap2_ff[21]}}, lap2_ff}) <<< 10) + 33'sd512;
      mean_q  = mean_prod2_ff[MEAN_SHIFT +: 17];
      case (mode)
         MODE_MEAN:      sel = $signed({7'd0, mean_q});
         MODE_MEDIAN:    sel = ext24(med3(lo2_ff, mid2_ff, hi2_ff));
         MODE_GAUSS:     sel = ext24(gauss2_ff);
         MODE_ROBERTS:   sel = $signed({7'd0, rob2_ff});
         MODE_PREWITT:   sel = $signed({5'd0, prew2_ff});
         MODE_SOBEL:     sel = $signed({5'd0, sob2_ff});
         MODE_LAPLACIAN: sel = $signed({3'd0, lap_abs2_ff});
         MODE_LOG:       sel = $signed({4'd0, log_abs2_ff});
         MODE_IMPROVED:  sel = $signed({imp_num[32], imp_num[32:10]});
         default:        sel = ext24(p2_ff);
      endcase
      if (ctl2_ff.pass) begin
         sel = ext24(p2_ff);
      end
      if (sel > 24'sd32767) begin
         sat = 16'sh7fff;
      end else if (sel < -24'sd32768) begin
         sat = -16'sh8000;
      end else begin
         sat = sel[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid <= 1'b0;
      end else if (en) begin
         out_valid <= v2_ff;
      end
      if (en) begin
         out_pixel <= sat;
         out_last  <= ctl2_ff.last;
      end
   end

endmodule
`default_nettype wire

// ===== sv/window_kernel_image_filter_top.sv =====
// Window kernel image filter: a result passes the line-memory read, window, kernel stage 1,
// stage 2 and result registers after the transfer that completes its window (the pixel two rows
// plus two pixels further on, or a flush transfer at frame end). One transfer per clock in each
// direction while no stalled result waits; the rate is set by the line memory, read and written
// back once per column, one port each way, per cycle. Reset clears positions and pipeline valids
// and sets mode 0, size 1024x1024; the line memory is not cleared and needs no clearing pass.
`default_nettype none
module window_kernel_image_filter_top (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [15:0]                 req_pixel_in,
   input  logic                        req_drain,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic signed [15:0]          rsp_pixel_out,
   output logic                        rsp_frame_last,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [wkf_pkg::ADDR_W-1:0]  csr_paddr,
   input  logic [31:0]                 csr_pwdata,
   output logic [31:0]                 csr_prdata,
   output logic                        csr_pready
);
   import wkf_pkg::*;

   // configuration
   logic [3:0]  mode_ff;
   logic [10:0] width_ff;
   logic [15:0] height_ff;
   logic        csr_wr, restart;
   logic [1:0]  csr_idx;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;
   assign csr_idx    = csr_paddr[3:2];
   assign restart    = csr_wr & ((csr_idx == REG_WIDTH) | (csr_idx == REG_HEIGHT));

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_MEAN;
         width_ff  <= 11'd1024;
         height_ff <= 16'd1024;
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_MODE:   mode_ff   <= csr_pwdata[3:0];
            REG_WIDTH:  width_ff  <= csr_pwdata[10:0];
            REG_HEIGHT: height_ff <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_MODE:   csr_prdata = {28'd0, mode_ff};
         REG_WIDTH:  csr_prdata = {21'd0, width_ff};
         REG_HEIGHT: csr_prdata = {16'd0, height_ff};
         default:    csr_prdata = 32'd0;
      endcase
   end

   // frame positions
   logic [10:0] wid_eff;
   logic [15:0] hgt_eff, hm1, hm2, hm3;
   col_type     wm1, wm2, wm3;
   col_type     col_ff, col_in, out_col_ff, out_col_in;
   logic [15:0] in_row_ff, in_row_in, out_row_ff, out_row_in;
   logic        en, done, proc, emit, out_last, int3, int5;
   ctl_type     ctl;

   always_comb begin
      if (width_ff < WIDTH_MIN) begin
         wid_eff = WIDTH_MIN;
      end else if (width_ff > WIDTH_MAX) begin
         wid_eff = WIDTH_MAX;
      end else begin
         wid_eff = width_ff;
      end
      hgt_eff = (height_ff < HEIGHT_MIN) ? HEIGHT_MIN : height_ff;
      wm1 = COL_W'(wid_eff - 11'd1);
      wm2 = COL_W'(wid_eff - 11'd2);
      wm3 = COL_W'(wid_eff - 11'd3);
      hm1 = hgt_eff - 16'd1;
      hm2 = hgt_eff - 16'd2;
      hm3 = hgt_eff - 16'd3;

      done = in_row_ff >= hgt_eff;
      // a pixel after the frame is complete only advances the flush
      proc = req_valid & en & (done | ~req_drain);
      emit = done | (in_row_ff > 16'd2) | ((in_row_ff == 16'd2) & (col_ff >= COL_W'(2)));
      out_last = (out_row_ff == hm1) & (out_col_ff == wm1);
      int3 = (out_row_ff >= 16'd1) & (out_row_ff <= hm2)
           & (out_col_ff >= COL_W'(1)) & (out_col_ff <= wm2);
      int5 = (out_row_ff >= 16'd2) & (out_row_ff <= hm3)
           & (out_col_ff >= COL_W'(2)) & (out_col_ff <= wm3);
      ctl.emit = emit;
      ctl.last = out_last;
      ctl.pass = (mode_ff > MODE_IMPROVED) | ((mode_ff == MODE_LOG) ? ~int5 : ~int3);

      col_in     = col_ff;
      in_row_in  = in_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      if (restart) begin
         col_in     = '0;
         in_row_in  = '0;
         out_col_in = '0;
         out_row_in = '0;
      end else if (proc) begin
         col_in = (col_ff == wm1) ? '0 : col_ff + COL_W'(1);
         if (!done && (col_ff == wm1)) begin
            in_row_in = in_row_ff + 16'd1;
         end
         if (emit) begin
            if (out_last) begin
               col_in     = '0;
               in_row_in  = '0;
               out_col_in = '0;
               out_row_in = '0;
            end else if (out_col_ff == wm1) begin
               out_col_in = '0;
               out_row_in = out_row_ff + 16'd1;
            end else begin
               out_col_in = out_col_ff + COL_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff     <= '0;
         in_row_ff  <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
      end else begin
         col_ff     <= col_in;
         in_row_ff  <= in_row_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
      end
   end

   // line memory: one entry per column holds the four previous rows of that column
   logic [LINE_W-1:0] line_mem [MAX_WIDTH];
   logic [LINE_W-1:0] rd_ff;
   logic              s1_proc_ff, s2_proc_ff;
   col_type           s1_col_ff;
   pix_type           s1_pix_ff;
   ctl_type           s1_ctl_ff, s2_ctl_ff;
   win_type           win_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (proc) begin
            rd_ff <= line_mem[col_ff];
         end
         if (s1_proc_ff) begin
            line_mem[s1_col_ff] <= {rd_ff[LINE_W-PIX_W-1:0], s1_pix_ff};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_proc_ff <= 1'b0;
         s2_proc_ff <= 1'b0;
      end else if (en) begin
         s1_proc_ff <= proc;
         s2_proc_ff <= s1_proc_ff;
      end
      if (en) begin
         s1_col_ff <= col_ff;
         s1_pix_ff <= done ? '0 : req_pixel_in;
         s1_ctl_ff <= ctl;
         // shift the window one column left and append the new column, oldest row first
         if (s1_proc_ff) begin
            s2_ctl_ff <= s1_ctl_ff;
            win_ff[0] <= win_ff[1];
            win_ff[1] <= win_ff[2];
            win_ff[2] <= win_ff[3];
            win_ff[3] <= win_ff[4];
            win_ff[4] <= {s1_pix_ff, rd_ff[15:0], rd_ff[31:16], rd_ff[47:32], rd_ff[63:48]};
         end
      end
   end

   // hold everything while a finished result waits
   assign en        = ~(rsp_valid & rsp_stall);
   assign req_stall = ~en;

   wkf_kernel u_kernel (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s2_proc_ff & s2_ctl_ff.emit),
      .in_ctl    (s2_ctl_ff),
      .win       (win_ff),
      .mode      (mode_ff),
      .out_valid (rsp_valid),
      .out_pixel (rsp_pixel_out),
      .out_last  (rsp_frame_last)
   );

endmodule
`default_nettype wire
